// ----- sv/cob_pkg.sv -----
// Shared constants, types and helpers for the cursor overlay blend block.
`timescale 1ns / 1ps
package cob_pkg;

   // Design limits
   localparam int MAX_CURSOR = 256;
   localparam int MAX_FRAME  = 8192;

   // Field widths
   localparam int CFG_W        = 14;
   localparam int CSR_INDEX_W  = 3;
   localparam int COORD_W      = 8;
   localparam int PIXEL_W      = 32;
   localparam int BYTE_W       = 8;
   localparam int LANES        = PIXEL_W / BYTE_W;
   localparam int OFFSET_W     = 26;

   // Derived widths
   localparam int FRAME_IDX_W  = $clog2(MAX_FRAME);
   localparam int CMP_W        = CFG_W + 2;
   localparam int CUR_CMP_W    = COORD_W + 1;
   localparam int PROD_W       = FRAME_IDX_W + CFG_W;
   localparam int SUM_W        = (PROD_W + 1 > OFFSET_W) ? PROD_W + 1 : OFFSET_W;
   localparam int WPROD_W      = 2 * BYTE_W;
   localparam int WSUM_W       = WPROD_W + 1;

   localparam logic [BYTE_W-1:0] FULL_ALPHA = 8'd255;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MONO_MODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_STRIDE   = 3'd5;

   // Reset values
   localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 14'd1920;
   localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 14'd1080;
   localparam logic [CFG_W-1:0] RST_ROW_STRIDE   = 14'd1920;

   // Result of the address stage
   typedef struct packed {
      logic                in_frame;
      logic [OFFSET_W-1:0] dest_offset;
   } addr_res_type;

   // Exact floor(v / 255) for v up to 255 * 255
   function automatic logic [BYTE_W-1:0] div255(input logic [WSUM_W-1:0] v);
      logic [WSUM_W-1:0] t;
      t = v + (v >> BYTE_W) + WSUM_W'(1);
      return t[2*BYTE_W-1:BYTE_W];
   endfunction

endpackage

// ----- sv/cob_lane.sv -----
// One byte lane of the alpha blend: weighted products, then sum and divide by 255.
`timescale 1ns / 1ps
module cob_lane (
   input  logic                       clock,
   input  logic                       load,
   input  logic [cob_pkg::BYTE_W-1:0] dst_byte,
   input  logic [cob_pkg::BYTE_W-1:0] src_byte,
   input  logic [cob_pkg::BYTE_W-1:0] alpha,
   output logic [cob_pkg::BYTE_W-1:0] blend_byte
);
   import cob_pkg::*;

   logic [WPROD_W-1:0] prod_d_ff, prod_d_in;
   logic [WPROD_W-1:0] prod_p_ff, prod_p_in;
   logic [WSUM_W-1:0]  sum;

   assign prod_d_in = {{BYTE_W{1'b0}}, dst_byte} * {{BYTE_W{1'b0}}, FULL_ALPHA - alpha};
   assign prod_p_in = {{BYTE_W{1'b0}}, src_byte} * {{BYTE_W{1'b0}}, alpha};

   always_ff @(posedge clock) begin
      if (load) begin
         prod_d_ff <= prod_d_in;
         prod_p_ff <= prod_p_in;
      end
   end

   assign sum        = {1'b0, prod_d_ff} + {1'b0, prod_p_ff};
   assign blend_byte = div255(sum);

endmodule

// ----- sv/cob_addr.sv -----
// Target position, frame clipping and row offset product for one request.
`timescale 1ns / 1ps
module cob_addr (
   input  logic                           clock,
   input  logic                           load,
   input  logic [cob_pkg::COORD_W-1:0]    cursor_row,
   input  logic [cob_pkg::COORD_W-1:0]    cursor_col,
   input  logic signed [cob_pkg::CFG_W-1:0] origin_x,
   input  logic signed [cob_pkg::CFG_W-1:0] origin_y,
   input  logic [cob_pkg::CFG_W-1:0]      frame_width,
   input  logic [cob_pkg::CFG_W-1:0]      frame_height,
   input  logic [cob_pkg::CFG_W-1:0]      row_stride,
   output cob_pkg::addr_res_type          res
);
   import cob_pkg::*;

   logic [CMP_W-1:0]       x_pos, y_pos;
   logic [CMP_W-1:0]       width_lim, height_lim;
   logic                   cursor_ok, x_ok, y_ok;
   logic                   inside_ff, inside_in;
   logic [FRAME_IDX_W-1:0] x_ff;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [SUM_W-1:0]       offset_sum;

   // Sign-extend origin, add the cursor index
   assign x_pos = {{(CMP_W-CFG_W){origin_x[CFG_W-1]}}, origin_x}
                + {{(CMP_W-COORD_W){1'b0}}, cursor_col};
   assign y_pos = {{(CMP_W-CFG_W){origin_y[CFG_W-1]}}, origin_y}
                + {{(CMP_W-COORD_W){1'b0}}, cursor_row};

   // Clamp frame size to the design limit
   assign width_lim  = ({2'b00, frame_width} > CMP_W'(MAX_FRAME))
                     ? CMP_W'(MAX_FRAME) : {2'b00, frame_width};
   assign height_lim = ({2'b00, frame_height} > CMP_W'(MAX_FRAME))
                     ? CMP_W'(MAX_FRAME) : {2'b00, frame_height};

   assign cursor_ok = ({1'b0, cursor_row} < CUR_CMP_W'(MAX_CURSOR))
                   && ({1'b0, cursor_col} < CUR_CMP_W'(MAX_CURSOR));
   assign x_ok      = !x_pos[CMP_W-1] && (x_pos < width_lim);
   assign y_ok      = !y_pos[CMP_W-1] && (y_pos < height_lim);
   assign inside_in = cursor_ok && x_ok && y_ok;

   assign prod_in = {{CFG_W{1'b0}}, y_pos[FRAME_IDX_W-1:0]}
                  * {{FRAME_IDX_W{1'b0}}, row_stride};

   always_ff @(posedge clock) begin
      if (load) begin
         inside_ff <= inside_in;
         x_ff      <= x_pos[FRAME_IDX_W-1:0];
         prod_ff   <= prod_in;
      end
   end

   assign offset_sum      = SUM_W'(prod_ff) + SUM_W'(x_ff);
   assign res.in_frame    = inside_ff;
   assign res.dest_offset = inside_ff ? offset_sum[OFFSET_W-1:0] : '0;

endmodule

// ----- sv/cursor_overlay_blend_top.sv -----
// Cursor overlay blend: composites one cursor pixel per request onto the frame.
// Path: an accepted request is registered in stage 1, then in the response register.
// Throughput: one request per cycle; a stalled response holds the pipeline once stage 1 is full.
// Stages: address and byte-lane multipliers, then sum/divide, offset add and merge.
// Reset: synchronous active-high reset empties the pipeline and restores registers
// (mono off, origin 0, frame 1920x1080, stride 1920).
`timescale 1ns / 1ps
module cursor_overlay_blend_top (
   input  logic                               clock,
   input  logic                               reset,
   // configuration write port
   input  logic                               csr_wr_en,
   input  logic [cob_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cob_pkg::CFG_W-1:0]          csr_wdata,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cob_pkg::COORD_W-1:0]        req_cursor_row,
   input  logic [cob_pkg::COORD_W-1:0]        req_cursor_col,
   input  logic [cob_pkg::PIXEL_W-1:0]        req_image_word,
   input  logic [cob_pkg::PIXEL_W-1:0]        req_mask_word,
   input  logic [cob_pkg::PIXEL_W-1:0]        req_frame_pixel,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_write_enable,
   output logic [cob_pkg::OFFSET_W-1:0]       rsp_dest_offset,
   output logic [cob_pkg::PIXEL_W-1:0]        rsp_new_pixel
);
   import cob_pkg::*;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic                    mono_mode_ff, mono_mode_in;
   logic signed [CFG_W-1:0] origin_x_ff, origin_x_in;
   logic signed [CFG_W-1:0] origin_y_ff, origin_y_in;
   logic [CFG_W-1:0]        frame_width_ff, frame_width_in;
   logic [CFG_W-1:0]        frame_height_ff, frame_height_in;
   logic [CFG_W-1:0]        row_stride_ff, row_stride_in;

   always_comb begin
      mono_mode_in    = mono_mode_ff;
      origin_x_in     = origin_x_ff;
      origin_y_in     = origin_y_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      row_stride_in   = row_stride_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MONO_MODE:    mono_mode_in    = csr_wdata[0];
            CSR_ORIGIN_X:     origin_x_in     = csr_wdata;
            CSR_ORIGIN_Y:     origin_y_in     = csr_wdata;
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            CSR_ROW_STRIDE:   row_stride_in   = csr_wdata;
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mono_mode_ff    <= 1'b0;
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         row_stride_ff   <= RST_ROW_STRIDE;
      end else begin
         mono_mode_ff    <= mono_mode_in;
         origin_x_ff     <= origin_x_in;
         origin_y_ff     <= origin_y_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         row_stride_ff   <= row_stride_in;
      end
   end

   // ---------------------------------------------------------------
   // Pipeline control: stage 1 (products) feeds the response register.
   // The response register takes a new value whenever it is empty or
   // being drained; stage 1 moves on under the same condition, so a
   // request enters while a finished response still waits, as long as
   // stage 1 itself is free.
   // ---------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_take;
   logic req_fire;

   assign out_take  = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_take;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire ? 1'b1 : (out_take ? 1'b0 : s1_valid_ff);
   assign out_valid_in = out_take ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1 payload carried alongside the lanes and address unit
   // ---------------------------------------------------------------
   logic [PIXEL_W-1:0] frame_ff;
   logic [PIXEL_W-1:0] mask_ff;
   logic               image_nz_ff;
   logic               mono_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         frame_ff    <= req_frame_pixel;
         mask_ff     <= req_mask_word;
         image_nz_ff <= |req_image_word;
         mono_ff     <= mono_mode_ff;
      end
   end

   // Address stage: clip and row offset
   addr_res_type addr_res;

   cob_addr u_addr (
      .clock        (clock),
      .load         (req_fire),
      .cursor_row   (req_cursor_row),
      .cursor_col   (req_cursor_col),
      .origin_x     (origin_x_ff),
      .origin_y     (origin_y_ff),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .row_stride   (row_stride_ff),
      .res          (addr_res)
   );

   // Four byte lanes, all weighted by the image alpha byte
   logic [PIXEL_W-1:0] blend_pixel;

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      cob_lane u_lane (
         .clock      (clock),
         .load       (req_fire),
         .dst_byte   (req_frame_pixel[k*BYTE_W +: BYTE_W]),
         .src_byte   (req_image_word[k*BYTE_W +: BYTE_W]),
         .alpha      (req_image_word[PIXEL_W-1 -: BYTE_W]),
         .blend_byte (blend_pixel[k*BYTE_W +: BYTE_W])
      );
   end

   // ---------------------------------------------------------------
   // Merge: pick the new pixel and register the response
   // ---------------------------------------------------------------
   logic                wr_ff, wr_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [PIXEL_W-1:0]  pixel_ff, pixel_in;

   always_comb begin
      wr_in     = addr_res.in_frame && image_nz_ff;
      offset_in = wr_in ? addr_res.dest_offset : '0;
      if (!wr_in) begin
         pixel_in = frame_ff;               // no write: pass the frame pixel
      end else if (mono_ff) begin
         pixel_in = frame_ff ^ mask_ff;     // monochrome XOR cursor
      end else begin
         pixel_in = blend_pixel;            // alpha blend
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         wr_ff     <= wr_in;
         offset_ff <= offset_in;
         pixel_ff  <= pixel_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_write_enable = wr_ff;
   assign rsp_dest_offset  = offset_ff;
   assign rsp_new_pixel    = pixel_ff;

`ifndef NO_ASSERTIONS
   // A skipped pixel never carries an offset
   a_no_write_zero_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_enable) |-> (rsp_dest_offset == '0))
      else $error("skipped pixel with nonzero offset");

   // An accepted request occupies stage 1 on the next cycle
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted request lost before stage 1");

   // A full stage 1 that cannot drain blocks new requests and keeps its request
   a_s1_blocked: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_take) |-> (!req_ready ##1 s1_valid_ff))
      else $error("stage 1 overwritten or dropped while stalled");

   // A stalled response keeps the response register full
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> out_valid_ff)
      else $error("response dropped while stalled");
`endif

endmodule

// ----- test/overlay_write_checker.sv -----
// Response checker for the cursor overlay blend block: predicts each pixel write and compares.
`timescale 1ns / 1ps
module overlay_write_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [cob_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cob_pkg::CFG_W-1:0]          csr_wdata,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [cob_pkg::COORD_W-1:0]        req_cursor_row,
   input  logic [cob_pkg::COORD_W-1:0]        req_cursor_col,
   input  logic [cob_pkg::PIXEL_W-1:0]        req_image_word,
   input  logic [cob_pkg::PIXEL_W-1:0]        req_mask_word,
   input  logic [cob_pkg::PIXEL_W-1:0]        req_frame_pixel,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_write_enable,
   input  logic [cob_pkg::OFFSET_W-1:0]       rsp_dest_offset,
   input  logic [cob_pkg::PIXEL_W-1:0]        rsp_new_pixel,
   output int unsigned                        outstanding,
   output int unsigned                        mismatch_count
);
   import cob_pkg::*;

   typedef struct packed {
      logic                write_enable;
      logic [OFFSET_W-1:0] dest_offset;
      logic [PIXEL_W-1:0]  new_pixel;
   } overlay_write_type;

   // shadow copy of the register file
   logic                   xor_cursor;
   logic signed [CFG_W-1:0] place_x;
   logic signed [CFG_W-1:0] place_y;
   logic [CFG_W-1:0]       visible_width;
   logic [CFG_W-1:0]       visible_height;
   logic [CFG_W-1:0]       line_pitch;

   overlay_write_type expected_writes[$];
   int unsigned       errors = 0;

   function automatic overlay_write_type blend_and_place(
      input logic [COORD_W-1:0] row,
      input logic [COORD_W-1:0] col,
      input logic [PIXEL_W-1:0] image,
      input logic [PIXEL_W-1:0] mask,
      input logic [PIXEL_W-1:0] frame
   );
      overlay_write_type w;
      int x, y, lim_w, lim_h, lin, a, d, p, k;
      x = place_x;
      x = x + int'(col);
      y = place_y;
      y = y + int'(row);
      lim_w = (int'(visible_width) > MAX_FRAME) ? MAX_FRAME : int'(visible_width);
      lim_h = (int'(visible_height) > MAX_FRAME) ? MAX_FRAME : int'(visible_height);
      w.write_enable = (image != '0) && (x >= 0) && (x < lim_w) && (y >= 0) && (y < lim_h);
      w.dest_offset = '0;
      w.new_pixel = frame;
      if (w.write_enable) begin
         lin = y * int'(line_pitch) + x;
         w.dest_offset = lin[OFFSET_W-1:0];
         if (xor_cursor) begin
            w.new_pixel = frame ^ mask;
         end else begin
            a = int'(image[PIXEL_W-1 -: BYTE_W]);
            for (k = 0; k < LANES; k++) begin
               d = int'(frame[BYTE_W*k +: BYTE_W]);
               p = int'(image[BYTE_W*k +: BYTE_W]);
               lin = (d * (int'(FULL_ALPHA) - a) + p * a) / int'(FULL_ALPHA);
               w.new_pixel[BYTE_W*k +: BYTE_W] = lin[BYTE_W-1:0];
            end
         end
      end
      return w;
   endfunction

   always @(posedge clock) begin
      overlay_write_type want;
      if (reset) begin
         xor_cursor = 1'b0;
         place_x = '0;
         place_y = '0;
         visible_width = RST_FRAME_WIDTH;
         visible_height = RST_FRAME_HEIGHT;
         line_pitch = RST_ROW_STRIDE;
         expected_writes.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MONO_MODE:    xor_cursor = csr_wdata[0];
               CSR_ORIGIN_X:     place_x = csr_wdata;
               CSR_ORIGIN_Y:     place_y = csr_wdata;
               CSR_FRAME_WIDTH:  visible_width = csr_wdata;
               CSR_FRAME_HEIGHT: visible_height = csr_wdata;
               CSR_ROW_STRIDE:   line_pitch = csr_wdata;
               default: ;
            endcase
         end
         // retire the oldest write before queuing a new one
         if (rsp_valid && rsp_ready) begin
            if (expected_writes.size() == 0) begin
               errors++;
               $display("%0t: response with no request pending, actual we=%0b offset=%h pixel=%h",
                        $time, rsp_write_enable, rsp_dest_offset, rsp_new_pixel);
            end else begin
               want = expected_writes.pop_front();
               if (rsp_write_enable !== want.write_enable) begin
                  errors++;
                  $display("%0t: write_enable expected %0b, actual %0b",
                           $time, want.write_enable, rsp_write_enable);
               end
               if (rsp_dest_offset !== want.dest_offset) begin
                  errors++;
                  $display("%0t: dest_offset expected %h, actual %h",
                           $time, want.dest_offset, rsp_dest_offset);
               end
               if (rsp_new_pixel !== want.new_pixel) begin
                  errors++;
                  $display("%0t: new_pixel expected %h, actual %h",
                           $time, want.new_pixel, rsp_new_pixel);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_writes.push_back(blend_and_place(req_cursor_row, req_cursor_col,
                                      req_image_word, req_mask_word, req_frame_pixel));
         end
      end
      outstanding <= expected_writes.size();
      mismatch_count <= errors;
   end

endmodule

// ----- test/cursor_overlay_blend_top_test.sv -----
// Testbench top for the cursor overlay blend block: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module cursor_overlay_blend_top_test;
   import cob_pkg::*;

   // indexes past the register file; the block must ignore them
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_REQUESTS = 50;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 8;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [COORD_W-1:0]     req_cursor_row = '0;
   logic [COORD_W-1:0]     req_cursor_col = '0;
   logic [PIXEL_W-1:0]     req_image_word = '0;
   logic [PIXEL_W-1:0]     req_mask_word = '0;
   logic [PIXEL_W-1:0]     req_frame_pixel = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_write_enable;
   logic [OFFSET_W-1:0]    rsp_dest_offset;
   logic [PIXEL_W-1:0]     rsp_new_pixel;

   int unsigned outstanding;
   int unsigned mismatch_count;

   // pacing controls shared by the sender and receiver processes
   bit calm = 1'b0;          // final phase: no idling on either side
   bit random_part = 1'b0;   // set once directed requests are done
   bit sender_gaps = 1'b0;   // per-phase switch for sender idle bursts

   always #5 clock = ~clock;

   cursor_overlay_blend_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cursor_row   (req_cursor_row),
      .req_cursor_col   (req_cursor_col),
      .req_image_word   (req_image_word),
      .req_mask_word    (req_mask_word),
      .req_frame_pixel  (req_frame_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_enable (rsp_write_enable),
      .rsp_dest_offset  (rsp_dest_offset),
      .rsp_new_pixel    (rsp_new_pixel)
   );

   overlay_write_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cursor_row   (req_cursor_row),
      .req_cursor_col   (req_cursor_col),
      .req_image_word   (req_image_word),
      .req_mask_word    (req_mask_word),
      .req_frame_pixel  (req_frame_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_enable (rsp_write_enable),
      .rsp_dest_offset  (rsp_dest_offset),
      .rsp_new_pixel    (rsp_new_pixel),
      .outstanding      (outstanding),
      .mismatch_count   (mismatch_count)
   );

   // Offer one request and hold it until the block takes it. Valid stays high on
   // return so back-to-back requests never drop it within a time step.
   task automatic send(
      input logic [COORD_W-1:0] row,
      input logic [COORD_W-1:0] col,
      input logic [PIXEL_W-1:0] image,
      input logic [PIXEL_W-1:0] mask,
      input logic [PIXEL_W-1:0] frame
   );
      req_valid <= 1'b1;
      req_cursor_row <= row;
      req_cursor_col <= col;
      req_image_word <= image;
      req_mask_word <= mask;
      req_frame_pixel <= frame;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and let every queued response drain. The first edge lets the
   // checker count a request accepted at the edge we were called on.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= CFG_W'(value);
      @(posedge clock);
   endtask

   // Reprogram every register while the pipeline is empty, plus one write to a
   // spare index that must leave the settings alone.
   task automatic load_settings(input int mode_word, input int ox, input int oy,
                                input int fw, input int fh, input int pitch);
      wait_drained();
      write_reg(CSR_MONO_MODE, mode_word);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_FRAME_WIDTH, fw);
      write_reg(CSR_FRAME_HEIGHT, fh);
      write_reg(CSR_ROW_STRIDE, pitch);
      write_reg(($urandom_range(0, 1) == 0) ? CSR_SPARE_LO : CSR_SPARE_HI, int'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   // Frame extent: mostly small so the cursor straddles the edges, sometimes
   // anything the register holds, sometimes right around the clamp.
   function automatic int pick_span();
      case ($urandom_range(0, 7))
         0: return int'($urandom_range(0, 16383));
         1: return int'($urandom_range(MAX_FRAME - 12, MAX_FRAME + 12));
         default: return int'($urandom_range(1, 400));
      endcase
   endfunction

   task automatic load_random_settings();
      int fw, fh, reach_w, reach_h, ox, oy, pitch;
      fw = pick_span();
      fh = pick_span();
      reach_w = (fw > MAX_FRAME) ? MAX_FRAME : fw;
      reach_h = (fh > MAX_FRAME) ? MAX_FRAME : fh;
      // place the cursor so it overlaps the frame most of the time
      if ($urandom_range(0, 3) == 0) ox = int'($urandom_range(0, 16383)) - 8192;
      else ox = int'($urandom_range(0, reach_w + 255)) - 255;
      if ($urandom_range(0, 3) == 0) oy = int'($urandom_range(0, 16383)) - 8192;
      else oy = int'($urandom_range(0, reach_h + 255)) - 255;
      case ($urandom_range(0, 5))
         0: pitch = 0;
         1: pitch = int'($urandom_range(0, 16383));
         default: pitch = reach_w + int'($urandom_range(0, 64));
      endcase
      load_settings(int'($urandom_range(0, 16383)), ox, oy, fw, fh, pitch);
   endtask

   task automatic send_random_pixel();
      logic [PIXEL_W-1:0] image;
      // bias toward transparent, opaque and zero-alpha cursor pixels
      case ($urandom_range(0, 9))
         0: image = '0;
         1: image = {FULL_ALPHA, 24'($urandom)};
         2: image = {8'h00, 24'($urandom)};
         default: image = $urandom;
      endcase
      send(COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)),
           image, $urandom, $urandom);
   endtask

   // Receiver: one long hold at the start of the random part so the pipeline
   // backs up into the request side, then random stall bursts, none at the end.
   initial begin
      bit held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (random_part && !held) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end else if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(30, 80)) @(posedge clock);
            else repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   // Hard stop in case the handshake hangs.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int ph, n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- reset settings: colour blend, origin 0, 1920x1080, stride 1920 ---
      // opaque cursor replaces the frame pixel
      send(8'd0, 8'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      // transparent image word: no write, frame pixel passes through
      send(8'd0, 8'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678);
      // half alpha at the far corner of the cursor image
      send(8'd255, 8'd255, 32'h80FF_00FF, 32'h0000_0000, 32'hFFFF_FFFF);
      // zero alpha but nonzero colour: written, frame value kept
      send(8'd7, 8'd9, 32'h00FF_FFFF, 32'hFFFF_FFFF, 32'hA5A5_A5A5);

      // --- most negative origin: everything lands left of and above the frame ---
      load_settings(16383, -8192, -8192, MAX_FRAME, MAX_FRAME, MAX_FRAME);
      send(8'd255, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
      send(8'd0, 8'd0, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF);

      // --- most positive origin, oversize frame clamped to the limit, widest stride ---
      // cursor origin lands on the last frame pixel; the offset wraps
      load_settings(1, 8191, 8191, 16383, 16383, 16383);
      send(8'd0, 8'd0, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h0F0F_0F0F);
      send(8'd0, 8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);

      // --- colour blend at the bottom right of a clamped frame, offset wraps ---
      load_settings(2, 7936, 7936, 16383, 16383, 16383);
      send(8'd255, 8'd255, 32'h7F80_4020, 32'hFFFF_FFFF, 32'hC0C0_C0C0);
      send(8'd255, 8'd255, 32'h0000_0000, 32'hFFFF_FFFF, 32'hDEAD_BEEF);

      // --- zero frame width clips every pixel ---
      load_settings(0, -5, 0, 0, 1080, 1920);
      send(8'd10, 8'd10, 32'hFFFF_FFFF, 32'h0000_0000, 32'h5555_5555);

      // --- one-pixel frame, zero stride, xor cursor ---
      load_settings(1, -5, -3, 1, 1, 0);
      send(8'd3, 8'd5, 32'h0000_0100, 32'hFFFF_0000, 32'h1234_5678);
      send(8'd3, 8'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678);
      send(8'd2, 8'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678);

      // --- zero stride: offset is just the column ---
      load_settings(8190, 1664, 824, 1920, 1080, 0);
      send(8'd255, 8'd255, 32'h01FF_8000, 32'h0000_0000, 32'h7F7F_7F7F);
      send(8'd0, 8'd0, 32'hFE01_02FD, 32'h0000_0000, 32'hFFFF_FFFF);

      // --- random phases, each under fresh settings ---
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == RANDOM_PHASES - 1) calm = 1'b1;
         load_random_settings();
         sender_gaps = ($urandom_range(0, 3) != 0);
         random_part = 1'b1;
         for (n = 0; n < PHASE_REQUESTS; n++) begin
            send_random_pixel();
            if (!calm && sender_gaps && $urandom_range(0, 4) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
      end

      // drain, then give the pipeline a few more cycles to show any stray response
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
